// ===== src/segment_triangle_test_core_assert.svh =====
// Assertion macros for the segment/triangle test core.
`ifndef SEGMENT_TRIANGLE_TEST_CORE_ASSERT_SVH
`define SEGMENT_TRIANGLE_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps
package stt_pkg;

  localparam int unsigned FieldW = 60;

endpackage

// ===== src/stt_diff.sv =====
`timescale 1ns / 1ps
module stt_diff import stt_pkg::*; #(
  parameter int unsigned CoordW = 20,
  localparam int unsigned DiffW = CoordW + 1,
  localparam int unsigned PackW = (3 * CoordW > FieldW) ? 3 * CoordW : FieldW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [FieldW-1:0]       vertex_a_i,
  input  logic [FieldW-1:0]       vertex_b_i,
  input  logic [FieldW-1:0]       vertex_c_i,
  input  logic [FieldW-1:0]       seg_start_i,
  input  logic [FieldW-1:0]       seg_end_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [DiffW-1:0] ab_o [3],
  output logic signed [DiffW-1:0] ac_o [3],
  output logic signed [DiffW-1:0] pq_o [3],
  output logic signed [DiffW-1:0] ap_o [3]
);

  logic [PackW-1:0]         a_x, b_x, c_x, s_x, e_x;
  logic signed [CoordW-1:0] va [3];
  logic signed [CoordW-1:0] vb [3];
  logic signed [CoordW-1:0] vc [3];
  logic signed [CoordW-1:0] sp [3];
  logic signed [CoordW-1:0] ep [3];
  logic signed [DiffW-1:0]  ab_d [3];
  logic signed [DiffW-1:0]  ac_d [3];
  logic signed [DiffW-1:0]  pq_d [3];
  logic signed [DiffW-1:0]  ap_d [3];
  logic signed [DiffW-1:0]  ab_q [3];
  logic signed [DiffW-1:0]  ac_q [3];
  logic signed [DiffW-1:0]  pq_q [3];
  logic signed [DiffW-1:0]  ap_q [3];
  logic                     valid_q;

  // bits past the field width read as zero
  always_comb begin
    a_x = PackW'(vertex_a_i);
    b_x = PackW'(vertex_b_i);
    c_x = PackW'(vertex_c_i);
    s_x = PackW'(seg_start_i);
    e_x = PackW'(seg_end_i);
    for (int k = 0; k < 3; k++) begin
      va[k]   = $signed(a_x[k*CoordW +: CoordW]);
      vb[k]   = $signed(b_x[k*CoordW +: CoordW]);
      vc[k]   = $signed(c_x[k*CoordW +: CoordW]);
      sp[k]   = $signed(s_x[k*CoordW +: CoordW]);
      ep[k]   = $signed(e_x[k*CoordW +: CoordW]);
      ab_d[k] = DiffW'(vb[k]) - DiffW'(va[k]);
      ac_d[k] = DiffW'(vc[k]) - DiffW'(va[k]);
      pq_d[k] = DiffW'(sp[k]) - DiffW'(ep[k]);
      ap_d[k] = DiffW'(sp[k]) - DiffW'(va[k]);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ab_q <= ab_d;
      ac_q <= ac_d;
      pq_q <= pq_d;
      ap_q <= ap_d;
    end
  end

  assign valid_o = valid_q;
  assign ab_o    = ab_q;
  assign ac_o    = ac_q;
  assign pq_o    = pq_q;
  assign ap_o    = ap_q;

endmodule

// ===== src/stt_cross.sv =====
`timescale 1ns / 1ps
module stt_cross import stt_pkg::*; #(
  parameter int unsigned CoordW = 20,
  localparam int unsigned DiffW = CoordW + 1,
  localparam int unsigned CrossW = 2 * CoordW + 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [DiffW-1:0]  ab_i [3],
  input  logic signed [DiffW-1:0]  ac_i [3],
  input  logic signed [DiffW-1:0]  pq_i [3],
  input  logic signed [DiffW-1:0]  ap_i [3],
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [DiffW-1:0]  ab_o [3],
  output logic signed [DiffW-1:0]  ac_o [3],
  output logic signed [DiffW-1:0]  pq_o [3],
  output logic signed [DiffW-1:0]  ap_o [3],
  output logic signed [CrossW-1:0] n_o [3],
  output logic signed [CrossW-1:0] ex_o [3]
);

  logic signed [CrossW-1:0] n_d [3];
  logic signed [CrossW-1:0] ex_d [3];
  logic signed [CrossW-1:0] n_q [3];
  logic signed [CrossW-1:0] ex_q [3];
  logic signed [DiffW-1:0]  ab_q [3];
  logic signed [DiffW-1:0]  ac_q [3];
  logic signed [DiffW-1:0]  pq_q [3];
  logic signed [DiffW-1:0]  ap_q [3];
  logic                     valid_q;

  // n = ab x ac, ex = pq x ap
  always_comb begin
    n_d[0]  = CrossW'(ab_i[1]) * CrossW'(ac_i[2]) - CrossW'(ab_i[2]) * CrossW'(ac_i[1]);
    n_d[1]  = CrossW'(ab_i[2]) * CrossW'(ac_i[0]) - CrossW'(ab_i[0]) * CrossW'(ac_i[2]);
    n_d[2]  = CrossW'(ab_i[0]) * CrossW'(ac_i[1]) - CrossW'(ab_i[1]) * CrossW'(ac_i[0]);
    ex_d[0] = CrossW'(pq_i[1]) * CrossW'(ap_i[2]) - CrossW'(pq_i[2]) * CrossW'(ap_i[1]);
    ex_d[1] = CrossW'(pq_i[2]) * CrossW'(ap_i[0]) - CrossW'(pq_i[0]) * CrossW'(ap_i[2]);
    ex_d[2] = CrossW'(pq_i[0]) * CrossW'(ap_i[1]) - CrossW'(pq_i[1]) * CrossW'(ap_i[0]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      n_q  <= n_d;
      ex_q <= ex_d;
      ab_q <= ab_i;
      ac_q <= ac_i;
      pq_q <= pq_i;
      ap_q <= ap_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign ex_o    = ex_q;
  assign ab_o    = ab_q;
  assign ac_o    = ac_q;
  assign pq_o    = pq_q;
  assign ap_o    = ap_q;

endmodule

// ===== src/stt_dot.sv =====
`timescale 1ns / 1ps
module stt_dot import stt_pkg::*; #(
  parameter int unsigned CoordW = 20,
  localparam int unsigned DiffW = CoordW + 1,
  localparam int unsigned CrossW = 2 * CoordW + 2,
  localparam int unsigned ProdW = DiffW + CrossW,
  localparam int unsigned SumW = 3 * CoordW + 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [DiffW-1:0]  ab_i [3],
  input  logic signed [DiffW-1:0]  ac_i [3],
  input  logic signed [DiffW-1:0]  pq_i [3],
  input  logic signed [DiffW-1:0]  ap_i [3],
  input  logic signed [CrossW-1:0] n_i [3],
  input  logic signed [CrossW-1:0] ex_i [3],
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [SumW-1:0]   d_o,
  output logic signed [SumW-1:0]   t_o,
  output logic signed [SumW-1:0]   v_o,
  output logic signed [SumW-1:0]   w_o
);

  logic signed [ProdW-1:0] pd_d [3];
  logic signed [ProdW-1:0] pt_d [3];
  logic signed [ProdW-1:0] pv_d [3];
  logic signed [ProdW-1:0] pw_d [3];
  logic signed [ProdW-1:0] pd_q [3];
  logic signed [ProdW-1:0] pt_q [3];
  logic signed [ProdW-1:0] pv_q [3];
  logic signed [ProdW-1:0] pw_q [3];
  logic signed [SumW-1:0]  d_d, t_d, v_d, w_d;
  logic signed [SumW-1:0]  d_q, t_q, v_q, w_q;
  logic                    prod_valid_q;
  logic                    sum_valid_q;
  logic                    prod_ready;
  logic                    sum_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pd_d[k] = ProdW'(pq_i[k]) * ProdW'(n_i[k]);
      pt_d[k] = ProdW'(ap_i[k]) * ProdW'(n_i[k]);
      pv_d[k] = ProdW'(ac_i[k]) * ProdW'(ex_i[k]);
      pw_d[k] = ProdW'(ab_i[k]) * ProdW'(ex_i[k]);
    end
  end

  always_comb begin
    d_d = SumW'(pd_q[0]) + SumW'(pd_q[1]) + SumW'(pd_q[2]);
    t_d = SumW'(pt_q[0]) + SumW'(pt_q[1]) + SumW'(pt_q[2]);
    v_d = SumW'(pv_q[0]) + SumW'(pv_q[1]) + SumW'(pv_q[2]);
    w_d = -(SumW'(pw_q[0]) + SumW'(pw_q[1]) + SumW'(pw_q[2]));
  end

  assign sum_ready  = !sum_valid_q || ready_i;
  assign prod_ready = !prod_valid_q || sum_ready;
  assign ready_o    = prod_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && prod_ready) begin
      pd_q <= pd_d;
      pt_q <= pt_d;
      pv_q <= pv_d;
      pw_q <= pw_d;
    end
    if (prod_valid_q && sum_ready) begin
      d_q <= d_d;
      t_q <= t_d;
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  assign valid_o = sum_valid_q;
  assign d_o     = d_q;
  assign t_o     = t_q;
  assign v_o     = v_q;
  assign w_o     = w_q;

endmodule

// ===== src/stt_decide.sv =====
`timescale 1ns / 1ps
module stt_decide import stt_pkg::*; #(
  parameter int unsigned CoordW = 20,
  localparam int unsigned SumW = 3 * CoordW + 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic signed [SumW-1:0] d_i,
  input  logic signed [SumW-1:0] t_i,
  input  logic signed [SumW-1:0] v_i,
  input  logic signed [SumW-1:0] w_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic                  hit_o
);

  logic signed [SumW:0] vw;
  logic signed [SumW:0] d_ext;
  logic                 hit_d;
  logic                 hit_q;
  logic                 valid_q;

  always_comb begin
    vw    = (SumW+1)'(v_i) + (SumW+1)'(w_i);
    d_ext = (SumW+1)'(d_i);
    hit_d = !d_i[SumW-1] && (|d_i)
         && !t_i[SumW-1] && (t_i <= d_i)
         && !v_i[SumW-1] && (v_i <= d_i)
         && !w_i[SumW-1] && (vw <= d_ext);
  end

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

// ===== src/segment_triangle_test_core.sv =====
`timescale 1ns / 1ps
// One-sided segment/triangle intersection test.
// Input channel: in_valid_i / in_stall_o with five packed points (vertex_a/b/c,
// seg_start, seg_end), each z,y,x of COORD_WIDTH-bit two's complement, x low.
// Output channel: out_valid_o / out_stall_i with hit_o, one result per item,
// in input order.
// Pipeline: edge differences, cross products, dot products, dot sums, bound
// checks; five register stages, the last one being the output register.
// An accepted item passes the diff, cross, product, sum and hit registers in
// turn; out_valid_o rises once the hit register holds its result.
// Throughput: one item per cycle while out_stall_i stays low; the widest path is
// one 22 x 44 bit multiply (at COORD_WIDTH = 21) in the dot-product stage.
// Each stage holds while the stage after it is full and stalled; empty stages
// keep filling, so the input is stalled only once the stage right after the
// input is full and cannot move.
// Reset clears every valid bit; the pipeline is empty and ready after reset.
module segment_triangle_test_core import stt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FieldW-1:0] vertex_a_i,
  input  logic [FieldW-1:0] vertex_b_i,
  input  logic [FieldW-1:0] vertex_c_i,
  input  logic [FieldW-1:0] seg_start_i,
  input  logic [FieldW-1:0] seg_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o
);

  `include "segment_triangle_test_core_assert.svh"

  localparam int unsigned DiffW  = COORD_WIDTH + 1;
  localparam int unsigned CrossW = 2 * COORD_WIDTH + 2;
  localparam int unsigned SumW   = 3 * COORD_WIDTH + 4;

  logic                     s1_valid, s1_ready;
  logic                     s2_valid, s2_ready;
  logic                     s4_valid, s3_ready;
  logic                     s5_ready;
  logic signed [DiffW-1:0]  ab1 [3];
  logic signed [DiffW-1:0]  ac1 [3];
  logic signed [DiffW-1:0]  pq1 [3];
  logic signed [DiffW-1:0]  ap1 [3];
  logic signed [DiffW-1:0]  ab2 [3];
  logic signed [DiffW-1:0]  ac2 [3];
  logic signed [DiffW-1:0]  pq2 [3];
  logic signed [DiffW-1:0]  ap2 [3];
  logic signed [CrossW-1:0] n2 [3];
  logic signed [CrossW-1:0] ex2 [3];
  logic signed [SumW-1:0]   d4, t4, v4, w4;

  stt_diff #(.CoordW(COORD_WIDTH)) u_diff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (s1_ready),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .vertex_c_i  (vertex_c_i),
    .seg_start_i (seg_start_i),
    .seg_end_i   (seg_end_i),
    .valid_o     (s1_valid),
    .ready_i     (s2_ready),
    .ab_o        (ab1),
    .ac_o        (ac1),
    .pq_o        (pq1),
    .ap_o        (ap1)
  );

  stt_cross #(.CoordW(COORD_WIDTH)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .ab_i    (ab1),
    .ac_i    (ac1),
    .pq_i    (pq1),
    .ap_i    (ap1),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .ab_o    (ab2),
    .ac_o    (ac2),
    .pq_o    (pq2),
    .ap_o    (ap2),
    .n_o     (n2),
    .ex_o    (ex2)
  );

  stt_dot #(.CoordW(COORD_WIDTH)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .ab_i    (ab2),
    .ac_i    (ac2),
    .pq_i    (pq2),
    .ap_i    (ap2),
    .n_i     (n2),
    .ex_i    (ex2),
    .valid_o (s4_valid),
    .ready_i (s5_ready),
    .d_o     (d4),
    .t_o     (t4),
    .v_o     (v4),
    .w_o     (w4)
  );

  stt_decide #(.CoordW(COORD_WIDTH)) u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid),
    .ready_o (s5_ready),
    .d_i     (d4),
    .t_i     (t4),
    .v_i     (v4),
    .w_i     (w4),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .hit_o   (hit_o)
  );

  assign in_stall_o = !s1_ready;

  `STT_ASSERT_NXT(a_accept_lands, in_valid_i && !in_stall_o, s1_valid, "accepted item lost")
  `STT_ASSERT_IMP(a_stall_full, in_stall_o, s1_valid, "input stalled with empty first stage")
  `STT_ASSERT_IMP(a_free_flow, !out_stall_i, !in_stall_o, "input stalled while output drains")

endmodule
